>>> hw/rtl/md5de_pkg.sv
package md5de_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int FILL_W      = $clog2(BLOCK_WORDS);
    localparam int ROUND_W     = 6;
    localparam int LEN_W       = 64;

    localparam logic [WORD_W-1:0] IV_A     = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B     = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV_C     = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV_D     = 32'h10325476;
    localparam logic [7:0]        PAD_BYTE = 8'h80;
    localparam logic [2:0]        WORD_BYTES = 3'd4;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;
    localparam logic [FILL_W-1:0]  LEN_SLOT   = 4'd14;
    localparam logic [FILL_W-1:0]  LAST_SLOT  = 4'd15;

    typedef logic [3:0] pc_t;

    // Microprogram addresses
    localparam pc_t PC_FETCH  = 4'd0;
    localparam pc_t PC_TAIL   = 4'd1;
    localparam pc_t PC_PAD    = 4'd2;
    localparam pc_t PC_FILL   = 4'd3;
    localparam pc_t PC_LEN_LO = 4'd4;
    localparam pc_t PC_LEN_HI = 4'd5;
    localparam pc_t PC_EMIT_A = 4'd6;
    localparam pc_t PC_EMIT_B = 4'd7;
    localparam pc_t PC_EMIT_C = 4'd8;
    localparam pc_t PC_EMIT_D = 4'd9;
    localparam pc_t PC_LOAD   = 4'd10;
    localparam pc_t PC_ROUND  = 4'd11;
    localparam pc_t PC_FOLD   = 4'd12;

    typedef enum logic [2:0] {
        OP_FETCH,
        OP_PUSH_TAIL,
        OP_PUSH,
        OP_FILL,
        OP_EMIT,
        OP_LOAD,
        OP_ROUND,
        OP_FOLD
    } op_t;

    typedef enum logic [2:0] {
        WSEL_INPUT,
        WSEL_TAIL,
        WSEL_PAD,
        WSEL_ZERO,
        WSEL_LEN_LO,
        WSEL_LEN_HI
    } wsel_t;

    typedef enum logic [1:0] {
        WORD_A,
        WORD_B,
        WORD_C,
        WORD_D
    } word_sel_t;

    typedef struct packed {
        op_t       op;
        wsel_t     wsel;
        word_sel_t word;
        pc_t       target;
    } ctrl_t;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } words_t;

    // Control store: one word per step
    function automatic ctrl_t ucode_rom(input pc_t pc);
        ctrl_t cw;
        unique case (pc)
            PC_FETCH:  cw = '{OP_FETCH,     WSEL_INPUT,  WORD_A, PC_TAIL};
            PC_TAIL:   cw = '{OP_PUSH_TAIL, WSEL_TAIL,   WORD_A, PC_FILL};
            PC_PAD:    cw = '{OP_PUSH,      WSEL_PAD,    WORD_A, PC_FILL};
            PC_FILL:   cw = '{OP_FILL,      WSEL_ZERO,   WORD_A, PC_LEN_LO};
            PC_LEN_LO: cw = '{OP_PUSH,      WSEL_LEN_LO, WORD_A, PC_LEN_HI};
            PC_LEN_HI: cw = '{OP_PUSH,      WSEL_LEN_HI, WORD_A, PC_EMIT_A};
            PC_EMIT_A: cw = '{OP_EMIT,      WSEL_ZERO,   WORD_A, PC_EMIT_B};
            PC_EMIT_B: cw = '{OP_EMIT,      WSEL_ZERO,   WORD_B, PC_EMIT_C};
            PC_EMIT_C: cw = '{OP_EMIT,      WSEL_ZERO,   WORD_C, PC_EMIT_D};
            PC_EMIT_D: cw = '{OP_EMIT,      WSEL_ZERO,   WORD_D, PC_FETCH};
            PC_LOAD:   cw = '{OP_LOAD,      WSEL_ZERO,   WORD_A, PC_ROUND};
            PC_ROUND:  cw = '{OP_ROUND,     WSEL_ZERO,   WORD_A, PC_FOLD};
            PC_FOLD:   cw = '{OP_FOLD,      WSEL_ZERO,   WORD_A, PC_FETCH};
            default:   cw = '{OP_FETCH,     WSEL_INPUT,  WORD_A, PC_FETCH};
        endcase
        return cw;
    endfunction

    // Message word used by a round
    function automatic logic [FILL_W-1:0] msg_index(input logic [ROUND_W-1:0] r);
        logic [FILL_W-1:0] r4;
        logic [FILL_W-1:0] g;
        r4 = r[3:0];
        unique case (r[5:4])
            2'd0: g = r4;
            2'd1: g = r4 * 4'd5 + 4'd1;
            2'd2: g = r4 * 4'd3 + 4'd5;
            2'd3: g = r4 * 4'd7;
        endcase
        return g;
    endfunction

    function automatic logic [4:0] shift_amount(input logic [ROUND_W-1:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            4'd15: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [WORD_W-1:0] sine_const(input logic [ROUND_W-1:0] r);
        logic [WORD_W-1:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
        endcase
        return k;
    endfunction

endpackage

>>> hw/rtl/md5de_ram.sv
module md5de_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/md5de_round.sv
module md5de_round (
    input  md5de_pkg::words_t                      words_in,
    input  logic [md5de_pkg::WORD_W-1:0]           msg_word,
    input  logic [md5de_pkg::ROUND_W-1:0]          round_num,
    output md5de_pkg::words_t                      words_out
);

    logic [md5de_pkg::WORD_W-1:0]   f;
    logic [md5de_pkg::WORD_W-1:0]   sum;
    logic [2*md5de_pkg::WORD_W-1:0] dbl;
    logic [md5de_pkg::WORD_W-1:0]   t;

    // Pick the round function for this quarter
    always_comb
    begin
        unique case (round_num[5:4])
            2'd0: f = (words_in.b & words_in.c) | (~words_in.b & words_in.d);
            2'd1: f = (words_in.b & words_in.d) | (words_in.c & ~words_in.d);
            2'd2: f = words_in.b ^ words_in.c ^ words_in.d;
            2'd3: f = words_in.c ^ (words_in.b | ~words_in.d);
        endcase
    end

    // Add, rotate left, add b
    assign sum = words_in.a + f + msg_word + md5de_pkg::sine_const(round_num);
    assign dbl = {sum, sum} << md5de_pkg::shift_amount(round_num);
    assign t   = words_in.b + dbl[2*md5de_pkg::WORD_W-1:md5de_pkg::WORD_W];

    // Rotate the working words
    assign words_out = '{a: words_in.d, b: t, c: words_in.b, d: words_in.c};

endmodule

>>> hw/rtl/md5_digest_engine.sv
// MD5 digest engine. Message words arrive on the slave stream as 32-bit little-endian words
// (first byte in bits 7:0); tlast marks the final word and tuser gives its valid byte count
// (0 to 4, larger values count as 4; non-final words always carry four bytes). After the
// final word the engine pads, appends the 64-bit bit length and sends the digest words A, B,
// C, D on the master stream with tuser as the word index and tlast on D. A non-final word
// is written into the block buffer; every sixteenth word adds a compression (load, 64
// rounds at one round per cycle, fold), during which no input is taken. The final word
// takes padding steps (tail, pad, zero fill, length low and high), one or two compressions
// and four output steps. Rounds run on the single round unit, which reads one block word
// per cycle from the block buffer RAM, under a small microcoded sequencer.
module md5_digest_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_word
    input  logic [2:0]  s_axis_tuser,   // [2:0] byte_count
    input  logic        s_axis_tlast,   // final_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);

    localparam int WordW  = md5de_pkg::WORD_W;
    localparam int FillW  = md5de_pkg::FILL_W;
    localparam int RoundW = md5de_pkg::ROUND_W;
    localparam int LenW   = md5de_pkg::LEN_W;

    localparam md5de_pkg::words_t IV = '{
        a: md5de_pkg::IV_A, b: md5de_pkg::IV_B, c: md5de_pkg::IV_C, d: md5de_pkg::IV_D
    };

    md5de_pkg::pc_t     pc_reg, pc_next;
    md5de_pkg::pc_t     ret_reg, ret_next;
    md5de_pkg::words_t  chain_reg, chain_next;
    md5de_pkg::words_t  round_reg, round_next;
    logic [RoundW-1:0]  round_num_reg, round_num_next;
    logic [FillW-1:0]   fill_reg, fill_next;
    logic [LenW-1:0]    bits_reg, bits_next;
    logic [WordW-1:0]   tail_reg, tail_next;
    logic               tail_full_reg, tail_full_next;
    logic               out_valid_reg, out_valid_next;
    logic [WordW-1:0]   out_data_reg, out_data_next;
    logic [1:0]         out_index_reg, out_index_next;
    logic               out_last_reg, out_last_next;

    md5de_pkg::ctrl_t   ctrl;
    md5de_pkg::words_t  round_out;
    logic               ram_we;
    logic [FillW-1:0]   ram_raddr;
    logic [WordW-1:0]   ram_wdata;
    logic [WordW-1:0]   ram_rdata;
    logic               in_accept;
    logic               out_free;
    logic               do_push;
    md5de_pkg::pc_t     after_pc;
    logic [2:0]         count_sat;
    logic [WordW-1:0]   keep_mask;
    logic [WordW-1:0]   pad_word;

    assign ctrl      = md5de_pkg::ucode_rom(pc_reg);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Block buffer
    md5de_ram #(
        .WIDTH (WordW),
        .DEPTH (md5de_pkg::BLOCK_WORDS)
    ) u_block_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // One compression round
    md5de_round u_round (
        .words_in  (round_reg),
        .msg_word  (ram_rdata),
        .round_num (round_num_reg),
        .words_out (round_out)
    );

    // Shape the final word: keep valid bytes, place the pad byte above them
    always_comb
    begin
        count_sat = (s_axis_tuser > md5de_pkg::WORD_BYTES) ? md5de_pkg::WORD_BYTES
                                                           : s_axis_tuser;
        unique case (count_sat)
            3'd0:    keep_mask = 32'h00000000;
            3'd1:    keep_mask = 32'h000000ff;
            3'd2:    keep_mask = 32'h0000ffff;
            3'd3:    keep_mask = 32'h00ffffff;
            default: keep_mask = 32'hffffffff;
        endcase
        pad_word = WordW'(md5de_pkg::PAD_BYTE) << {count_sat[1:0], 3'b000};
    end

    // Select the word written into the block buffer
    always_comb
    begin
        unique case (ctrl.wsel)
            md5de_pkg::WSEL_INPUT:  ram_wdata = s_axis_tdata;
            md5de_pkg::WSEL_TAIL:   ram_wdata = tail_reg;
            md5de_pkg::WSEL_PAD:    ram_wdata = WordW'(md5de_pkg::PAD_BYTE);
            md5de_pkg::WSEL_ZERO:   ram_wdata = '0;
            md5de_pkg::WSEL_LEN_LO: ram_wdata = bits_reg[WordW-1:0];
            md5de_pkg::WSEL_LEN_HI: ram_wdata = bits_reg[LenW-1:WordW];
            default:                ram_wdata = '0;
        endcase
    end

    // Sequencer: execute the current control word
    always_comb
    begin
        pc_next        = pc_reg;
        ret_next       = ret_reg;
        chain_next     = chain_reg;
        round_next     = round_reg;
        round_num_next = round_num_reg;
        fill_next      = fill_reg;
        bits_next      = bits_reg;
        tail_next      = tail_reg;
        tail_full_next = tail_full_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_raddr      = '0;
        s_axis_tready  = 1'b0;
        do_push        = 1'b0;
        after_pc       = pc_reg;

        unique case (ctrl.op)
            md5de_pkg::OP_FETCH:
            begin
                s_axis_tready = 1'b1;
                if (in_accept)
                begin
                    if (s_axis_tlast)
                    begin
                        bits_next      = bits_reg + LenW'({count_sat, 3'b000});
                        tail_full_next = (count_sat == md5de_pkg::WORD_BYTES);
                        tail_next      = (count_sat == md5de_pkg::WORD_BYTES)
                                       ? s_axis_tdata
                                       : ((s_axis_tdata & keep_mask) | pad_word);
                        pc_next        = ctrl.target;
                    end
                    else
                    begin
                        bits_next = bits_reg + LenW'(WordW);
                        do_push   = 1'b1;
                        after_pc  = pc_reg;
                    end
                end
            end
            md5de_pkg::OP_PUSH_TAIL:
            begin
                do_push  = 1'b1;
                after_pc = tail_full_reg ? md5de_pkg::PC_PAD : ctrl.target;
            end
            md5de_pkg::OP_PUSH:
            begin
                do_push  = 1'b1;
                after_pc = ctrl.target;
            end
            md5de_pkg::OP_FILL:
            begin
                if (fill_reg == md5de_pkg::LEN_SLOT)
                begin
                    pc_next = ctrl.target;
                end
                else
                begin
                    do_push  = 1'b1;
                    after_pc = pc_reg;
                end
            end
            md5de_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = ctrl.word;
                    out_last_next  = (ctrl.word == md5de_pkg::WORD_D);
                    unique case (ctrl.word)
                        md5de_pkg::WORD_A: out_data_next = chain_reg.a;
                        md5de_pkg::WORD_B: out_data_next = chain_reg.b;
                        md5de_pkg::WORD_C: out_data_next = chain_reg.c;
                        md5de_pkg::WORD_D: out_data_next = chain_reg.d;
                        default:           out_data_next = chain_reg.a;
                    endcase
                    // Last digest word: start over for the next message
                    if (ctrl.word == md5de_pkg::WORD_D)
                    begin
                        chain_next = IV;
                        bits_next  = '0;
                    end
                    pc_next = ctrl.target;
                end
            end
            md5de_pkg::OP_LOAD:
            begin
                round_next = chain_reg;
                ram_raddr  = md5de_pkg::msg_index('0);
                pc_next    = ctrl.target;
            end
            md5de_pkg::OP_ROUND:
            begin
                round_next     = round_out;
                round_num_next = round_num_reg + RoundW'(1);
                ram_raddr      = md5de_pkg::msg_index(round_num_reg + RoundW'(1));
                if (round_num_reg == md5de_pkg::LAST_ROUND)
                begin
                    pc_next = ctrl.target;
                end
            end
            md5de_pkg::OP_FOLD:
            begin
                chain_next.a = chain_reg.a + round_reg.a;
                chain_next.b = chain_reg.b + round_reg.b;
                chain_next.c = chain_reg.c + round_reg.c;
                chain_next.d = chain_reg.d + round_reg.d;
                fill_next    = '0;
                pc_next      = ret_reg;
            end
            default:
            begin
                pc_next = md5de_pkg::PC_FETCH;
            end
        endcase

        // Write one block word; a full block calls the compression
        if (do_push)
        begin
            ram_we    = 1'b1;
            fill_next = fill_reg + FillW'(1);
            if (fill_reg == md5de_pkg::LAST_SLOT)
            begin
                ret_next = after_pc;
                pc_next  = md5de_pkg::PC_LOAD;
            end
            else
            begin
                pc_next = after_pc;
            end
        end
    end

    // Control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= md5de_pkg::PC_FETCH;
            ret_reg       <= md5de_pkg::PC_FETCH;
            chain_reg     <= IV;
            round_reg     <= '0;
            round_num_reg <= '0;
            fill_reg      <= '0;
            bits_reg      <= '0;
            tail_full_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            ret_reg       <= ret_next;
            chain_reg     <= chain_next;
            round_reg     <= round_next;
            round_num_reg <= round_num_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            tail_full_reg <= tail_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tail_reg      <= tail_next;
        out_data_reg  <= out_data_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_index_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // The round counter moves only inside the round loop
    assert property (@(posedge clk) disable iff (!rst_n)
        (round_num_reg != '0) |-> (ctrl.op == md5de_pkg::OP_ROUND))
        else $error("round counter active outside the round loop");

    // No input is taken while a compression is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (round_num_reg == '0) && (ctrl.op == md5de_pkg::OP_FETCH))
        else $error("input ready during compression");

    // Folding empties the block buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == md5de_pkg::OP_FOLD) |=> (fill_reg == '0))
        else $error("fill position not cleared after fold");

    // The last digest word is word D
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == md5de_pkg::WORD_D)))
        else $error("tlast does not match word D");

    // The final round hands over to the fold step
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == md5de_pkg::OP_ROUND) && (round_num_reg == md5de_pkg::LAST_ROUND)
        |=> (pc_reg == md5de_pkg::PC_FOLD))
        else $error("round loop did not end in fold");
`endif

endmodule

>>> test/md5_digest_engine_test.sv
module md5_digest_engine_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_AT_WORD   = 30;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 200;

    // one message word as offered on the slave stream
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        is_last;
    } msg_word_t;

    // one digest word as expected on the master stream
    typedef struct packed {
        logic [31:0]          digest;
        md5de_pkg::word_sel_t index;
        logic                 is_last;
    } digest_word_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] data_word
    logic [2:0]  s_axis_tuser = '0;     // [2:0] byte_count
    logic        s_axis_tlast = 1'b0;   // final_item
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] digest_word
    logic [1:0]  m_axis_tuser;          // [1:0] word_index
    logic        m_axis_tlast;          // last_word

    md5_digest_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // per-round additive constants and rotate amounts of the compression
    logic [31:0] sine_k [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    int rot_amt [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    // digest state mirrored on the testbench side
    logic [31:0] chain_h [4] = '{md5de_pkg::IV_A, md5de_pkg::IV_B,
                                 md5de_pkg::IV_C, md5de_pkg::IV_D};
    logic [31:0] block_words [16];
    int          fill_cnt = 0;
    logic [63:0] bit_len = '0;

    msg_word_t    pending_words [$];
    digest_word_t digest_expected [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_taken = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // run the 64 rounds over the buffered block and fold into the chain
    function automatic void compress_block();
        logic [31:0] a, b, c, d, f, t;
        int g, s, q;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        for (int r = 0; r < 64; r++)
        begin
            q = r / 16;
            case (q)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            s = rot_amt[q * 4 + r % 4];
            t = a + f + block_words[g] + sine_k[r];
            t = b + ((t << s) | (t >> (32 - s)));
            a = d;
            d = c;
            c = b;
            b = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
    endfunction

    function automatic void append_word(input logic [31:0] w);
        block_words[fill_cnt] = w;
        fill_cnt++;
        if (fill_cnt == 16)
        begin
            compress_block();
            fill_cnt = 0;
        end
    endfunction

    // absorb one accepted word; on the last word pad, close and queue the digest
    function automatic void predict_digest(input msg_word_t mw);
        int n;
        logic [31:0] keep;
        digest_word_t dw;
        if (!mw.is_last)
        begin
            bit_len += 64'd32;
            append_word(mw.data);
            return;
        end
        n = (mw.nbytes > md5de_pkg::WORD_BYTES) ? 4 : int'(mw.nbytes);
        bit_len += 64'(8 * n);
        if (n == 4)
        begin
            append_word(mw.data);
            append_word({24'h0, md5de_pkg::PAD_BYTE});
        end
        else
        begin
            keep = (n == 0) ? 32'h0 : (32'hffffffff >> (32 - 8 * n));
            append_word((mw.data & keep) | ({24'h0, md5de_pkg::PAD_BYTE} << (8 * n)));
        end
        while (fill_cnt != 14)
            append_word(32'h0);
        append_word(bit_len[31:0]);
        append_word(bit_len[63:32]);
        for (int k = 0; k < 4; k++)
        begin
            dw.digest  = chain_h[k];
            dw.index   = md5de_pkg::word_sel_t'(k);
            dw.is_last = (k == 3);
            digest_expected.push_back(dw);
        end
        chain_h  = '{md5de_pkg::IV_A, md5de_pkg::IV_B, md5de_pkg::IV_C, md5de_pkg::IV_D};
        fill_cnt = 0;
        bit_len  = '0;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] digest %s: got %h, want %h", $time, field, got, want);
        mismatches++;
    endtask

    // queue one message: body words with junk byte counts, then the closing word
    task automatic queue_message(input int body_len, input logic [2:0] last_count,
                                 input logic [31:0] last_data);
        msg_word_t mw;
        for (int i = 0; i < body_len; i++)
        begin
            case ($urandom_range(0, 7))
                0: mw.data = 32'hffffffff;
                1: mw.data = 32'h0;
                default: mw.data = $urandom;
            endcase
            mw.nbytes  = 3'($urandom_range(0, 7));
            mw.is_last = 1'b0;
            pending_words.push_back(mw);
        end
        mw.data    = last_data;
        mw.nbytes  = last_count;
        mw.is_last = 1'b1;
        pending_words.push_back(mw);
    endtask

    task automatic queue_random_messages(input int n_words);
        int added;
        int len;
        logic [2:0] cnt;
        added = 0;
        while (added < n_words)
        begin
            if ($urandom_range(0, 9) < 7)
                len = $urandom_range(0, 15);
            else
                len = $urandom_range(13, 35);
            if ($urandom_range(0, 9) < 8)
                cnt = 3'($urandom_range(0, 4));
            else
                cnt = 3'($urandom_range(5, 7));
            queue_message(len, cnt, $urandom);
            added += len + 1;
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_axis_tvalid || digest_expected.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // slave side: offer queued words, predict on each accepted one
    always @(posedge clk)
    begin : drive_words
        msg_word_t nxt;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_digest(msg_word_t'{s_axis_tdata, s_axis_tuser, s_axis_tlast});
                words_taken <= words_taken + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tuser  <= nxt.nbytes;
                    s_axis_tlast  <= nxt.is_last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // master side: check accepted digest words, stall at random or for one long hold
    always @(posedge clk)
    begin : check_digest
        digest_word_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (digest_expected.size() == 0)
                begin
                    report_mismatch("unexpected word", m_axis_tdata, 32'h0);
                end
                else
                begin
                    want = digest_expected.pop_front();
                    if (m_axis_tdata !== want.digest)
                        report_mismatch("value", m_axis_tdata, want.digest);
                    if (m_axis_tuser !== want.index)
                        report_mismatch("index", 32'(m_axis_tuser), 32'(want.index));
                    if (m_axis_tlast !== want.is_last)
                        report_mismatch("last flag", 32'(m_axis_tlast), 32'(want.is_last));
                end
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && words_taken >= HOLD_AT_WORD)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // give up when neither stream moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sender sparse gaps, receiver mostly stalled
        send_idle_pct = 24;
        recv_idle_pct = 88;
        // empty message, with bytes that must be dropped
        queue_message(0, 3'd0, 32'hffffffff);
        // partial closing words, then full and oversized byte counts
        queue_message(0, 3'd1, 32'hffffffff);
        queue_message(0, 3'd2, 32'hffffffff);
        queue_message(0, 3'd3, 32'hffffffff);
        queue_message(0, 3'd4, 32'h0);
        queue_message(0, 3'd5, 32'ha5c3_5a3c);
        queue_message(0, 3'd6, 32'hffffffff);
        queue_message(0, 3'd7, 32'h1234_5678);
        // full last word pushes the pad into slot 14, so the length spills into a second block
        queue_message(13, 3'd4, 32'hffffffff);
        queue_random_messages(20);
        wait_drained();

        // sender mostly idle, receiver rarely stalls
        send_idle_pct = 88;
        recv_idle_pct = 24;
        queue_random_messages(30);
        wait_drained();

        // back to back on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_messages(30);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && digest_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
